>>> rtl/lbpc_pkg.sv
// lbpc_pkg: shared types and constants of the local binary pattern coder
// no dependencies; used by every other file of the block but lbpc_ram through scoped names

package lbpc_pkg;

  localparam int PixW    = 8;   // grey level and code width
  localparam int ImgW    = 12;  // image_width / image_height register width
  localparam int OrderW  = 36;  // neighbour_order register width
  localparam int CfgIdxW = 2;   // configuration register index width
  localparam int Kernel  = 3;   // window edge length

  localparam int          ResetWidth  = 640;
  localparam int          ResetHeight = 480;
  localparam logic [OrderW-1:0] ResetOrder = 36'h7654F3210;

  typedef logic [PixW-1:0] pix_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_NEIGHBOUR_ORDER = 2'd2
  } cfg_reg_e;

  // one accepted item as handed from the position control to the window stage
  typedef struct packed {
    logic feed;      // item shifts the window
    logic dbl;       // two virtual positions in one item
    logic emit;      // a code leaves for this item
    logic last;      // code of the frame's last pixel
    logic top_ok;    // row above the centre is inside the frame
    logic bot_ok;    // row below the centre is inside the frame
    logic left_ok;   // column left of the centre is inside the frame
    logic right_ok;  // column right of the centre is inside the frame
    pix_t px;        // new bottom-right pixel
  } job_t;

endpackage

>>> rtl/lbpc_intf.sv
// lbpc_intf: valid/ready channel interfaces of the pattern coder
// depends on lbpc_pkg for payload widths

interface lbpc_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [lbpc_pkg::PixW-1:0] pixel_value;

  modport source (output valid, op, pixel_value, input ready);
  modport sink   (input valid, op, pixel_value, output ready);
endinterface

interface lbpc_code_if;
  logic                     valid;
  logic                     ready;
  logic [lbpc_pkg::PixW-1:0] code;
  logic                     frame_end;

  modport source (output valid, code, frame_end, input ready);
  modport sink   (input valid, code, frame_end, output ready);
endinterface

interface lbpc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lbpc_pkg::CfgIdxW-1:0] index;
  logic [lbpc_pkg::OrderW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/local_binary_pattern_codes.sv
// local_binary_pattern_codes: top level of the 3x3 local binary pattern coder
// depends on lbpc_pkg, lbpc_intf, lbpc_ram, lbpc_ctrl, lbpc_core
//
// channel | dir | payload                     | transfer when
// pix_i   | in  | op, pixel_value             | valid && ready
// code_o  | out | code, frame_end             | valid && ready
// cfg_i   | in  | index, data (36 bit)        | valid && ready (ready always high)
//
// one item per clock while no output stall holds the window stage; the code of an item
// passes the line store read, then window and compare into the result reg
// the rate is set by the single line store read port pair per item
// reset clears counters and handshakes and loads the register defaults; the line store is not cleared
// an output stall holds one item in the window stage, after which pix_i.ready drops

module local_binary_pattern_codes #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lbpc_pix_if.sink            pix_i,
  lbpc_code_if.source         code_o,
  lbpc_cfg_if.sink            cfg_i
);

  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int RamDepth = 2 * (2 ** ColW);  // two row banks

  logic                        fire, cfg_fire, take;
  lbpc_pkg::job_t              job;
  logic [lbpc_pkg::OrderW-1:0] order;
  logic                        we;
  logic [ColW:0]               waddr, raddr_a, raddr_b;
  lbpc_pkg::pix_t              wdata, rdata_a, rdata_b;

  // config writes must be issued only while the block is idle; the block does not enforce this
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  assign pix_i.ready = take;
  assign fire        = pix_i.valid && take;

  // position counters, geometry and line store addressing
  lbpc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_fire_i    (cfg_fire),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .fire_i        (fire),
    .op_i          (pix_i.op),
    .pixel_value_i (pix_i.pixel_value),
    .job_o         (job),
    .order_o       (order),
    .we_o          (we),
    .waddr_o       (waddr),
    .raddr_a_o     (raddr_a),
    .raddr_b_o     (raddr_b),
    .wdata_o       (wdata)
  );

  // two previous rows, one bank per row parity
  lbpc_ram #(
    .WIDTH (lbpc_pkg::PixW),
    .DEPTH (RamDepth)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (fire),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // window, compares and result register
  lbpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .job_i       (job),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .order_i     (order),
    .take_o      (take),
    .out_ready_i (code_o.ready),
    .out_valid_o (code_o.valid),
    .code_o      (code_o.code),
    .frame_end_o (code_o.frame_end)
  );

endmodule

>>> rtl/lbpc_ram.sv
// lbpc_ram: generic RAM, one write port and two registered read ports
// no dependencies

module lbpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> rtl/lbpc_ctrl.sv
// lbpc_ctrl: configuration registers, input/output position counters,
// line store addressing; depends on lbpc_pkg

module lbpc_ctrl #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_fire_i,
  input  logic [lbpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lbpc_pkg::OrderW-1:0]  cfg_data_i,
  input  logic                         fire_i,
  input  logic                         op_i,
  input  lbpc_pkg::pix_t               pixel_value_i,
  output lbpc_pkg::job_t               job_o,
  output logic [lbpc_pkg::OrderW-1:0]  order_o,
  output logic                         we_o,
  output logic [$clog2(MAX_WIDTH):0]   waddr_o,
  output logic [$clog2(MAX_WIDTH):0]   raddr_a_o,
  output logic [$clog2(MAX_WIDTH):0]   raddr_b_o,
  output lbpc_pkg::pix_t               wdata_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = lbpc_pkg::ImgW + 1;
  localparam int ResetColLast =
    (lbpc_pkg::ResetWidth > MAX_WIDTH) ? MAX_WIDTH - 1 : lbpc_pkg::ResetWidth - 1;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } pos_t;

  logic [ColW-1:0]             col_last_q, col_last_d;
  logic [lbpc_pkg::ImgW-1:0]   row_last_q, row_last_d;
  logic [lbpc_pkg::OrderW-1:0] order_q;
  pos_t                        in_q, out_q, in_d, out_d;

  logic [lbpc_pkg::ImgW-1:0] cfg_val;
  logic [RowW-1:0]           row_last_x;
  logic                      restart, flush_on, dbl, lag, emit, last;
  pos_t                      cur_in, cur_out, in_one;

  function automatic pos_t step_pos(pos_t p, logic [ColW-1:0] col_last);
    pos_t n;
    n = p;
    if (p.col == col_last) begin
      n.row = p.row + RowW'(1);
      n.col = '0;
    end else begin
      n.col = p.col + ColW'(1);
    end
    return n;
  endfunction

  assign cfg_val    = cfg_data_i[lbpc_pkg::ImgW-1:0];
  assign row_last_x = {1'b0, row_last_q};

  // effective geometry, stored as last index
  always_comb begin
    if (cfg_val == '0) begin
      col_last_d = '0;
    end else if (32'(cfg_val) > MAX_WIDTH) begin
      col_last_d = ColW'(MAX_WIDTH - 1);
    end else begin
      col_last_d = ColW'(cfg_val - lbpc_pkg::ImgW'(1));
    end
    row_last_d = (cfg_val == '0) ? '0 : cfg_val - lbpc_pkg::ImgW'(1);
  end

  always_comb begin
    restart  = !op_i && (in_q.row > row_last_x);
    flush_on = op_i && (in_q.row > row_last_x) && ({1'b0, out_q.row} <= {1'b0, row_last_x});
    dbl      = flush_on && (in_q.row == RowW'(1)) && (in_q.col == '0);
    cur_in   = restart ? '0 : in_q;
    cur_out  = restart ? '0 : out_q;
    lag      = (cur_in.row > RowW'(1)) || ((cur_in.row == RowW'(1)) && (cur_in.col != '0));
    emit     = (!op_i && lag) || flush_on;
    last     = emit && (cur_out.row == row_last_x) && (cur_out.col == col_last_q);

    in_one = step_pos(cur_in, col_last_q);
    in_d   = dbl ? step_pos(in_one, col_last_q) : in_one;
    out_d  = emit ? step_pos(cur_out, col_last_q) : cur_out;
    if (last) begin
      in_d  = '0;
      out_d = '0;
    end

    job_o.feed     = !op_i || flush_on;
    job_o.dbl      = dbl;
    job_o.emit     = emit;
    job_o.last     = last;
    job_o.top_ok   = cur_out.row != '0;
    job_o.bot_ok   = cur_out.row != row_last_x;
    job_o.left_ok  = cur_out.col != '0;
    job_o.right_ok = cur_out.col != col_last_q;
    job_o.px       = op_i ? '0 : pixel_value_i;
  end

  // bank = row parity; the double step reads the middle bank at columns 0 and 1
  assign we_o      = fire_i && !op_i;
  assign wdata_o   = pixel_value_i;
  assign waddr_o   = {cur_in.row[0], cur_in.col};
  assign raddr_a_o = {dbl ? ~cur_in.row[0] : cur_in.row[0], cur_in.col};
  assign raddr_b_o = {~cur_in.row[0], dbl ? cur_in.col + ColW'(1) : cur_in.col};
  assign order_o   = order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= ColW'(ResetColLast);
      row_last_q <= lbpc_pkg::ImgW'(lbpc_pkg::ResetHeight - 1);
      order_q    <= lbpc_pkg::ResetOrder;
      in_q       <= '0;
      out_q      <= '0;
    end else if (cfg_fire_i) begin
      case (cfg_index_i)
        lbpc_pkg::CFG_IMAGE_WIDTH: begin
          col_last_q <= col_last_d;
          in_q       <= '0;
          out_q      <= '0;
        end
        lbpc_pkg::CFG_IMAGE_HEIGHT: begin
          row_last_q <= row_last_d;
          in_q       <= '0;
          out_q      <= '0;
        end
        lbpc_pkg::CFG_NEIGHBOUR_ORDER: begin
          order_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end else if (fire_i && job_o.feed) begin
      in_q  <= in_d;
      out_q <= out_d;
    end
  end

endmodule

>>> rtl/lbpc_core.sv
// lbpc_core: 3x3 window stage, pattern compare and result register
// depends on lbpc_pkg; line store data comes from lbpc_ram

module lbpc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  lbpc_pkg::job_t              job_i,
  input  lbpc_pkg::pix_t              rdata_a_i,
  input  lbpc_pkg::pix_t              rdata_b_i,
  input  logic [lbpc_pkg::OrderW-1:0] order_i,
  output logic                        take_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output lbpc_pkg::pix_t              code_o,
  output logic                        frame_end_o
);

  localparam int K = lbpc_pkg::Kernel;

  lbpc_pkg::job_t s1_q;
  logic           s1_valid_q;
  logic           out_valid_q;
  lbpc_pkg::pix_t code_q, code_d;
  logic           frame_end_q;
  lbpc_pkg::pix_t win_q [K][K];
  lbpc_pkg::pix_t win_d [K][K];
  lbpc_pkg::pix_t col_new [K];
  lbpc_pkg::pix_t col_dbl [K];
  logic [K-1:0]   row_ok, col_ok;
  logic [3:0]     entry;
  logic           s1_adv, out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && (!s1_q.emit || out_free);
  assign take_o   = !s1_valid_q || s1_adv;

  // window shift; double step keeps only the middle row, the rest is masked
  always_comb begin
    col_new[0] = rdata_a_i;
    col_new[1] = rdata_b_i;
    col_new[2] = s1_q.px;
    col_dbl[0] = '0;
    col_dbl[1] = rdata_a_i;
    col_dbl[2] = '0;
    for (int r = 0; r < K; r++) begin
      if (s1_q.dbl) begin
        win_d[r][0] = win_q[r][2];
        win_d[r][1] = col_dbl[r];
        win_d[r][2] = (r == 1) ? rdata_b_i : lbpc_pkg::pix_t'(0);
      end else begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
        win_d[r][2] = col_new[r];
      end
    end
  end

  // nine independent compares against the centre
  always_comb begin
    row_ok = {s1_q.bot_ok, 1'b1, s1_q.top_ok};
    col_ok = {s1_q.right_ok, 1'b1, s1_q.left_ok};
    code_d = '0;
    entry  = '0;
    for (int ki = 0; ki < K; ki++) begin
      for (int kj = 0; kj < K; kj++) begin
        entry = order_i[4*(K*ki+kj) +: 4];
        if (row_ok[ki] && col_ok[kj] && !entry[3] && (win_d[ki][kj] >= win_d[1][1])) begin
          code_d[entry[2:0]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_i) begin
        s1_valid_q <= job_i.feed;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      s1_q <= job_i;
    end
    if (s1_adv) begin
      win_q <= win_d;
      if (s1_q.emit) begin
        code_q      <= code_d;
        frame_end_q <= s1_q.last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;
  assign frame_end_o = frame_end_q;

endmodule

>>> tb/lbpc_checker.sv
// lbpc_checker: watches the pixel, code and register channels of the pattern coder,
// predicts every code from its own copy of the window state and compares in order
// depends on lbpc_pkg and the channel interfaces in lbpc_intf
`timescale 1ns / 1ps

module lbpc_checker #(
  parameter int   MAX_WIDTH = 2048,
  parameter logic FLUSH_OP  = 1'b1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lbpc_pix_if   pix_mon,
  lbpc_code_if  code_mon,
  lbpc_cfg_if   cfg_mon,
  output int    errors_o,
  output int    due_o
);

  localparam int ImgW   = lbpc_pkg::ImgW;
  localparam int OrderW = lbpc_pkg::OrderW;
  localparam int Kernel = lbpc_pkg::Kernel;

  typedef lbpc_pkg::pix_t pix_t;

  typedef struct packed {
    pix_t code;
    logic frame_end;
  } lbp_result_t;

  lbp_result_t due_codes[$];

  // shadow registers
  logic [ImgW-1:0]   width_q;
  logic [ImgW-1:0]   height_q;
  logic [OrderW-1:0] order_q;

  // shadow frame state
  pix_t        rows_mem [2][MAX_WIDTH];
  pix_t        win [Kernel][Kernel];
  int unsigned in_col, in_row, out_col, out_row;

  function automatic int unsigned frame_w();
    if (width_q == '0) return 1;
    if (int'(width_q) > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_q);
  endfunction

  function automatic int unsigned frame_h();
    return (height_q == '0) ? 1 : int'(height_q);
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    for (int r = 0; r < Kernel; r++)
      for (int c = 0; c < Kernel; c++)
        win[r][c] = '0;
  endfunction

  // shift one raster position into the window; true once the lag is reached
  function automatic bit shift_in(bit is_pixel, pix_t px);
    int unsigned col;
    bit          lagged;
    col = (in_col < MAX_WIDTH) ? in_col : 0;
    for (int r = 0; r < Kernel; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = rows_mem[in_row & 1][col];
    win[1][2] = rows_mem[(in_row + 1) & 1][col];
    win[2][2] = is_pixel ? px : '0;
    if (is_pixel) rows_mem[in_row & 1][col] = px;
    lagged = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= frame_w()) begin
      in_col = 0;
      in_row++;
    end
    return lagged;
  endfunction

  // pattern code of the pixel at the output position
  function automatic lbp_result_t code_at_out();
    int unsigned w, h, sel;
    int          nr, nc;
    pix_t        centre;
    lbp_result_t res;
    w = frame_w();
    h = frame_h();
    centre = win[1][1];
    res = '0;
    for (int ki = 0; ki < Kernel; ki++) begin
      for (int kj = 0; kj < Kernel; kj++) begin
        nr = int'(out_row) + ki - 1;
        nc = int'(out_col) + kj - 1;
        if (nr >= 0 && nc >= 0 && nr < int'(h) && nc < int'(w)) begin
          sel = 32'(order_q[4*(Kernel*ki+kj) +: 4]);
          if (sel < 8 && win[ki][kj] >= centre) res.code[sel] = 1'b1;
        end
      end
    end
    res.frame_end = (out_row == h - 1) && (out_col == w - 1);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (res.frame_end) restart_frame();
    return res;
  endfunction

  function automatic bit predict_code(logic op, pix_t px, output lbp_result_t res);
    res = '0;
    if (op != FLUSH_OP) begin
      // pixel after the frame's last pixel starts the next frame
      if (in_row >= frame_h()) restart_frame();
      if (shift_in(1'b1, px)) begin
        res = code_at_out();
        return 1'b1;
      end
      return 1'b0;
    end
    if (in_row < frame_h() || out_row >= frame_h()) return 1'b0;
    for (int i = 0; i < 2; i++) begin
      if (shift_in(1'b0, '0)) begin
        res = code_at_out();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lbp_result_t res, want;
    if (!rst_ni) begin
      width_q  = ImgW'(lbpc_pkg::ResetWidth);
      height_q = ImgW'(lbpc_pkg::ResetHeight);
      order_q  = lbpc_pkg::ResetOrder;
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < MAX_WIDTH; c++)
          rows_mem[b][c] = '0;
      restart_frame();
      due_codes.delete();
      errors_o = 0;
      due_o    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (lbpc_pkg::cfg_reg_e'(cfg_mon.index))
          lbpc_pkg::CFG_IMAGE_WIDTH: begin
            width_q = cfg_mon.data[ImgW-1:0];
            restart_frame();
          end
          lbpc_pkg::CFG_IMAGE_HEIGHT: begin
            height_q = cfg_mon.data[ImgW-1:0];
            restart_frame();
          end
          lbpc_pkg::CFG_NEIGHBOUR_ORDER: begin
            order_q = cfg_mon.data;
          end
          default: ;
        endcase
      end
      if (pix_mon.valid && pix_mon.ready) begin
        if (predict_code(pix_mon.op, pix_mon.pixel_value, res)) due_codes.push_back(res);
      end
      if (code_mon.valid && code_mon.ready) begin
        if (due_codes.size() == 0) begin
          $error("unexpected code transfer: code %0d frame_end %0b",
                 code_mon.code, code_mon.frame_end);
          errors_o++;
        end else begin
          want = due_codes.pop_front();
          if (code_mon.code !== want.code) begin
            $error("code mismatch: expected %0d, got %0d", want.code, code_mon.code);
            errors_o++;
          end
          if (code_mon.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, got %0b",
                   want.frame_end, code_mon.frame_end);
            errors_o++;
          end
        end
      end
      due_o = due_codes.size();
    end
  end

endmodule

>>> tb/tb.sv
// tb: stimulus and verdict for local_binary_pattern_codes
// depends on lbpc_pkg, lbpc_intf, the block and tb/lbpc_checker
`timescale 1ns / 1ps

module tb;

  localparam int          ImgW         = lbpc_pkg::ImgW;
  localparam int          OrderW       = lbpc_pkg::OrderW;
  localparam int          MaxWidth     = 2048;
  localparam logic        OpPixel      = 1'b0;
  localparam logic        OpFlush      = 1'b1;
  // frame shapes: complete, drain cut short, pixels cut short
  localparam int unsigned FrameFull    = 0;
  localparam int unsigned FrameDrainCut = 1;
  localparam int unsigned FrameCut     = 2;
  // settle a little longer after draining before a register write
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandomPixels = 440;

  typedef lbpc_pkg::pix_t pix_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   due;

  // geometry as the block uses it, tracked on every register write
  int unsigned frame_w = lbpc_pkg::ResetWidth;
  int unsigned frame_h = lbpc_pkg::ResetHeight;
  int unsigned pixels_sent;
  int unsigned send_calm;
  bit          hold_req = 1'b0;

  lbpc_pix_if  pix_if ();
  lbpc_code_if code_if ();
  lbpc_cfg_if  cfg_if ();

  local_binary_pattern_codes #(
    .MAX_WIDTH(MaxWidth)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pix_i (pix_if),
    .code_o(code_if),
    .cfg_i (cfg_if)
  );

  lbpc_checker #(
    .MAX_WIDTH(MaxWidth),
    .FLUSH_OP (OpFlush)
  ) u_checker (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pix_mon (pix_if),
    .code_mon(code_if),
    .cfg_mon (cfg_if),
    .errors_o(errors),
    .due_o   (due)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // gap length: mostly none, some short, a few long, with idle-free stretches
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // grey level by frame style: full range, narrow band, black/white, flat
  function automatic pix_t pick_level(int unsigned mode, pix_t base);
    case (mode)
      0: return pix_t'($urandom);
      1: return base + pix_t'($urandom_range(0, 2));
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return base;
    endcase
  endfunction

  // code sink: random back-pressure, plus one long hold-off on request
  initial begin : code_sink
    int unsigned gap;
    int unsigned calm;
    calm = 0;
    code_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long stall so the window fills and pixel input backs up
        hold_req = 1'b0;
        code_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      gap = draw_gap(calm);
      if (gap != 0) begin
        code_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      code_if.ready = 1'b1;
    end
  end

  // every task is entered and left at a falling edge
  task automatic send_item(logic op, pix_t px);
    int unsigned gap;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid       = 1'b1;
    pix_if.op          = op;
    pix_if.pixel_value = px;
    do @(posedge clk); while (!pix_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pix_if.valid = 1'b0;
    while (due != 0) @(negedge clk);
  endtask

  task automatic write_reg(lbpc_pkg::cfg_reg_e idx, logic [OrderW-1:0] val);
    int unsigned v;
    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    v = 32'(val[ImgW-1:0]);
    case (idx)
      lbpc_pkg::CFG_IMAGE_WIDTH:  frame_w = (v == 0) ? 1 : ((v > MaxWidth) ? MaxWidth : v);
      lbpc_pkg::CFG_IMAGE_HEIGHT: frame_h = (v == 0) ? 1 : v;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    if ($urandom_range(0, 1)) begin
      write_reg(lbpc_pkg::CFG_IMAGE_WIDTH, OrderW'(w));
      write_reg(lbpc_pkg::CFG_IMAGE_HEIGHT, OrderW'(h));
    end else begin
      write_reg(lbpc_pkg::CFG_IMAGE_HEIGHT, OrderW'(h));
      write_reg(lbpc_pkg::CFG_IMAGE_WIDTH, OrderW'(w));
    end
  endtask

  // one frame of random pixels followed by the flushes that drain it
  task automatic run_frame(int unsigned style);
    int unsigned total, drains, npix, mode;
    pix_t        base;
    total  = frame_w * frame_h;
    // the last row plus one pixel is still pending once all pixels are in
    drains = (total < frame_w + 1) ? total : frame_w + 1;
    npix   = total;
    if (style == FrameCut && total > 1) npix = $urandom_range(1, total - 1);
    mode = $urandom_range(0, 3);
    base = pix_t'($urandom);
    for (int unsigned p = 0; p < npix; p++) begin
      // stray flush inside the frame is dropped by the block
      if ($urandom_range(0, 49) == 0) send_item(OpFlush, pix_t'($urandom));
      send_item(OpPixel, pick_level(mode, base));
      pixels_sent++;
    end
    if (style == FrameCut) return;
    if (style == FrameDrainCut) begin
      // next pixel arrives mid-drain and abandons the rest
      drains = $urandom_range(0, drains - 1);
    end else if ($urandom_range(0, 4) == 0) begin
      drains += $urandom_range(1, 2);
    end
    repeat (drains) send_item(OpFlush, pix_t'($urandom));
  endtask

  task automatic random_phase();
    int unsigned r, w, h, nframes, style;
    logic [OrderW-1:0] order;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      // width register 0 acts as one column
      w = $urandom_range(0, 1);
      h = $urandom_range(1, 6);
    end else if (r == 1) begin
      // height register 0 acts as one row
      w = $urandom_range(1, 20);
      h = $urandom_range(0, 1);
    end else if (r == 9) begin
      w = $urandom_range(17, 40);
      h = $urandom_range(2, 6);
    end else begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 8);
    end
    set_geometry(w, h);
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 5);
      if (r == 0) order = '0;
      else if (r == 1) order = '1;
      else if (r == 2) order = lbpc_pkg::ResetOrder;
      else order = OrderW'({$urandom, $urandom});
      write_reg(lbpc_pkg::CFG_NEIGHBOUR_ORDER, order);
    end
    nframes = $urandom_range(1, 3);
    for (int unsigned f = 0; f < nframes; f++) begin
      r = $urandom_range(0, 9);
      if (r < 8) style = FrameFull;
      else if (r == 8) style = FrameDrainCut;
      else style = (f == nframes - 1) ? FrameCut : FrameFull;
      run_frame(style);
      // occasional pause until every pending code has come out
      if ($urandom_range(0, 6) == 0) wait_drained();
    end
  endtask

  initial begin
    pix_if.valid       = 1'b0;
    pix_if.op          = OpPixel;
    pix_if.pixel_value = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = lbpc_pkg::CFG_IMAGE_WIDTH;
    cfg_if.data        = '0;
    send_calm          = 0;
    pixels_sent        = 0;
    rst_n              = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: 2x2 frame with extreme levels, exact drain, one ignored flush
    write_reg(lbpc_pkg::CFG_IMAGE_WIDTH, OrderW'(2));
    write_reg(lbpc_pkg::CFG_IMAGE_HEIGHT, OrderW'(2));
    send_item(OpPixel, 8'd255);
    send_item(OpPixel, 8'd0);
    send_item(OpPixel, 8'd128);
    send_item(OpPixel, 8'd128);
    repeat (4) send_item(OpFlush, 8'hFF);

    // centre enabled, two neighbours sharing a bit, ignored entries
    write_reg(lbpc_pkg::CFG_NEIGHBOUR_ORDER, 36'hF77908100);
    write_reg(lbpc_pkg::CFG_IMAGE_WIDTH, OrderW'(3));
    write_reg(lbpc_pkg::CFG_IMAGE_HEIGHT, OrderW'(2));
    send_item(OpPixel, 8'd0);
    send_item(OpPixel, 8'd255);
    send_item(OpPixel, 8'd7);
    send_item(OpPixel, 8'd7);
    send_item(OpPixel, 8'd255);
    send_item(OpPixel, 8'd0);
    send_item(OpFlush, 8'h00);
    // pixel during drain starts the next frame, one flush inside it is dropped
    send_item(OpPixel, 8'd7);
    send_item(OpPixel, 8'd0);
    send_item(OpPixel, 8'd255);
    send_item(OpFlush, 8'h55);
    send_item(OpPixel, 8'd255);
    send_item(OpPixel, 8'd7);
    send_item(OpPixel, 8'd128);
    repeat (4) send_item(OpFlush, 8'hAA);
    wait_drained();

    // first random frame runs against a long output hold-off
    set_geometry(32, 6);
    write_reg(lbpc_pkg::CFG_NEIGHBOUR_ORDER, lbpc_pkg::ResetOrder);
    hold_req = 1'b1;
    run_frame(FrameFull);

    pixels_sent = 0;
    while (pixels_sent < RandomPixels) random_phase();

    // wider line with a full second row, then a tall single column
    set_geometry(96, 2);
    write_reg(lbpc_pkg::CFG_NEIGHBOUR_ORDER, OrderW'({$urandom, $urandom}));
    run_frame(FrameFull);
    set_geometry(1, 150);
    run_frame(FrameFull);

    wait_drained();
    repeat (2 * SettleCycles) @(negedge clk);
    if (errors == 0 && due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #25_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
